// ===== rtl/sac_pkg.sv =====
`default_nettype none

package sac_pkg;

  localparam int unsigned WAYS = 4;
  localparam int unsigned SET_BITS = 6;
  localparam int unsigned ADDR_BITS = 48;
  localparam int unsigned OFF_BITS = 5;

  localparam int unsigned NUM_SETS = 1 << SET_BITS;
  localparam int unsigned SET_W = (SET_BITS > 0) ? SET_BITS : 1;

  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic [SET_W-1:0] set;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/sac_ram.sv =====
`default_nettype none

module sac_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic                 re_i,
  input  wire logic [AddrW-1:0]     addr_i,
  input  wire logic [Width-1:0]     wdata_i,
  output      logic [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/sac_cell.sv =====
`default_nettype none

module sac_cell (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire sac_pkg::cell_ctrl_t            ctrl_i,
  input  wire logic [sac_pkg::ADDR_BITS-1:0]  key_i,
  input  wire logic [sac_pkg::ADDR_BITS-1:0]  wr_tag_i,
  input  wire logic                           wr_vld_i,
  output      logic [sac_pkg::ADDR_BITS-1:0]  rd_tag_o,
  output      logic                           rd_vld_o,
  output      logic                           match_o
);

  logic [sac_pkg::NUM_SETS-1:0] vld_q;
  logic                         rd_vld_q;

  sac_ram #(
    .Width(sac_pkg::ADDR_BITS),
    .Depth(sac_pkg::NUM_SETS)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (ctrl_i.wr_en),
    .re_i   (ctrl_i.rd_en),
    .addr_i (ctrl_i.set),
    .wdata_i(wr_tag_i),
    .rdata_o(rd_tag_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctrl_i.wr_en) begin
        vld_q[ctrl_i.set] <= wr_vld_i;
      end
      if (ctrl_i.rd_en) begin
        rd_vld_q <= vld_q[ctrl_i.set];
      end
    end
  end

  assign rd_vld_o = rd_vld_q;
  assign match_o  = rd_vld_q && (rd_tag_o == key_i);

endmodule

`default_nettype wire

// ===== rtl/set_assoc_cache_lru.sv =====
// Channel  | Handshake                 | Payload
// config   | cfg_we_i                  | cfg_wdata_i (offset bits)
// input    | in_valid_i / in_ready_o   | addr_i
// output   | out_valid_o / out_ready_i | hit_o, evicted_o
//
// Each word is handled in two steps: a read of the set from every way cell's tag RAM,
// then a compare that picks the way and shifts the recency chain by one cell.
// The next word is accepted in the cycle after the chain update.
// Reset clears all valid bits at once and sets the offset width to 4.
// A result that is not taken holds the chain update until the output register frees.
`default_nettype none

module set_assoc_cache_lru (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [sac_pkg::OFF_BITS-1:0]   cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output      logic                           in_ready_o,
  input  wire logic [sac_pkg::ADDR_BITS-1:0]  addr_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_ready_i,
  output      logic                           hit_o,
  output      logic                           evicted_o
);

  logic [sac_pkg::OFF_BITS-1:0]  off_q;
  logic                          busy_q;
  logic                          out_valid_q;
  logic                          hit_q;
  logic                          evicted_q;
  logic [sac_pkg::ADDR_BITS-1:0] tag_q;
  logic [sac_pkg::SET_W-1:0]     set_q;

  logic [sac_pkg::ADDR_BITS-1:0] shifted;
  logic [sac_pkg::SET_W-1:0]     in_set;
  logic [sac_pkg::ADDR_BITS-1:0] in_tag;
  logic                          accept;
  logic                          done;

  logic [sac_pkg::ADDR_BITS-1:0] rd_tag [sac_pkg::WAYS];
  logic [sac_pkg::WAYS-1:0]      rd_vld;
  logic [sac_pkg::WAYS-1:0]      match;
  logic [sac_pkg::WAYS-1:0]      stop;
  logic [sac_pkg::WAYS-1:0]      shift_en;
  logic                          hit;
  logic                          evict;

  assign shifted = addr_i >> off_q;
  assign in_set  = (sac_pkg::SET_BITS == 0) ? '0 : shifted[sac_pkg::SET_W-1:0];
  assign in_tag  = shifted >> sac_pkg::SET_BITS;

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && !busy_q;
  assign done       = busy_q && (!out_valid_q || out_ready_i);

  assign hit   = |match;
  assign evict = !hit && (&rd_vld);
  assign stop  = hit ? match : ~rd_vld;

  always_comb begin
    shift_en[0] = 1'b1;
    for (int i = 1; i < sac_pkg::WAYS; i++) begin
      shift_en[i] = shift_en[i-1] && !stop[i-1];
    end
  end

  for (genvar g = 0; g < sac_pkg::WAYS; g++) begin : g_cell
    sac_pkg::cell_ctrl_t           ctrl;
    logic [sac_pkg::ADDR_BITS-1:0] wr_tag;
    logic                          wr_vld;

    assign ctrl.rd_en = accept;
    assign ctrl.wr_en = done && shift_en[g];
    assign ctrl.set   = busy_q ? set_q : in_set;

    if (g == 0) begin : g_head
      assign wr_tag = tag_q;
      assign wr_vld = 1'b1;
    end else begin : g_link
      assign wr_tag = rd_tag[g-1];
      assign wr_vld = rd_vld[g-1];
    end

    sac_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .key_i   (tag_q),
      .wr_tag_i(wr_tag),
      .wr_vld_i(wr_vld),
      .rd_tag_o(rd_tag[g]),
      .rd_vld_o(rd_vld[g]),
      .match_o (match[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q       <= sac_pkg::OFF_BITS'(4);
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        off_q <= cfg_wdata_i;
      end
      if (accept) begin
        busy_q <= 1'b1;
      end else if (done) begin
        busy_q <= 1'b0;
      end
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tag_q <= in_tag;
      set_q <= in_set;
    end
    if (done) begin
      hit_q     <= hit;
      evicted_q <= evict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign evicted_o   = evicted_q;

endmodule

`default_nettype wire

// ===== tb/tb_set_assoc_cache_lru.sv =====
`timescale 1ns / 100ps

module tb_set_assoc_cache_lru;

  typedef struct packed {
    logic hit;
    logic evicted;
  } lookup_t;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned ITEMS_PER_PHASE = 160;
  localparam int unsigned PHASES = 8;
  localparam int unsigned TAG_POOL = 6;
  localparam int unsigned SET_POOL = 4;
  localparam int unsigned REPORT_MAX = 10;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [sac_pkg::OFF_BITS-1:0]  cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic [sac_pkg::ADDR_BITS-1:0] addr = '0;
  logic                          out_ready = 1'b0;
  logic                          in_ready;
  logic                          out_valid;
  logic                          hit;
  logic                          evicted;

  set_assoc_cache_lru u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .addr_i      (addr),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .hit_o       (hit),
    .evicted_o   (evicted)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the cache: each set in recency order, way 0 most recent.
  logic [sac_pkg::ADDR_BITS-1:0] tag_mem [sac_pkg::NUM_SETS][sac_pkg::WAYS];
  logic                          line_ok [sac_pkg::NUM_SETS][sac_pkg::WAYS];
  logic [sac_pkg::OFF_BITS-1:0]  offset_q;

  logic [sac_pkg::ADDR_BITS-1:0] addr_backlog [$];
  lookup_t              lookup_q [$];
  int unsigned          send_idle_pct = 0;
  int unsigned          stall_pct = 0;
  int unsigned          fail_count = 0;
  int unsigned          idle_cycles = 0;
  bit                   word_held;

  function automatic lookup_t cache_lookup(logic [sac_pkg::ADDR_BITS-1:0] a);
    int unsigned                   set_idx;
    int unsigned                   sh;
    logic [sac_pkg::ADDR_BITS-1:0] tag;
    int                            pos;
    int                            i;
    lookup_t                       r;
    sh = int'(offset_q) + sac_pkg::SET_BITS;
    set_idx = int'((a >> offset_q) & (sac_pkg::NUM_SETS - 1));
    tag = a >> sh;
    r = '0;
    pos = -1;
    for (i = 0; i < sac_pkg::WAYS; i++) begin
      if (pos < 0 && line_ok[set_idx][i] && tag_mem[set_idx][i] == tag) begin
        pos = i;
        r.hit = 1'b1;
      end
    end
    if (!r.hit) begin
      for (i = 0; i < sac_pkg::WAYS; i++) begin
        if (pos < 0 && !line_ok[set_idx][i]) pos = i;
      end
      if (pos < 0) begin
        pos = sac_pkg::WAYS - 1;
        r.evicted = 1'b1;
      end
    end
    for (i = pos; i > 0; i--) begin
      tag_mem[set_idx][i] = tag_mem[set_idx][i-1];
      line_ok[set_idx][i] = line_ok[set_idx][i-1];
    end
    tag_mem[set_idx][0] = tag;
    line_ok[set_idx][0] = 1'b1;
    return r;
  endfunction

  function automatic logic [sac_pkg::ADDR_BITS-1:0] make_addr(logic [63:0] tag,
                                                              int unsigned set_idx,
                                                              int unsigned off,
                                                              logic [63:0] low);
    logic [63:0] a;
    a = (tag << (off + sac_pkg::SET_BITS)) | (64'(set_idx % sac_pkg::NUM_SETS) << off) |
        (low & ((64'd1 << off) - 64'd1));
    return a[sac_pkg::ADDR_BITS-1:0];
  endfunction

  task automatic flag(string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) $display("%0t: %s", $time, msg);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (addr_backlog.size() != 0 || in_valid || lookup_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      addr <= '0;
    end else begin
      word_held = in_valid;
      if (in_valid && in_ready) begin
        lookup_q.push_back(cache_lookup(addr));
        word_held = 1'b0;
      end
      if (!word_held) begin
        if (addr_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          addr <= addr_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    lookup_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (lookup_q.size() == 0) begin
        flag($sformatf("unexpected word hit=%0b evicted=%0b", hit, evicted));
      end else begin
        want = lookup_q.pop_front();
        if (hit !== want.hit) begin
          flag($sformatf("hit mismatch: expected %0b, got %0b", want.hit, hit));
        end
        if (evicted !== want.evicted) begin
          flag($sformatf("evicted mismatch: expected %0b, got %0b", want.evicted, evicted));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("set_assoc_cache_lru regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [63:0] tag_pool [TAG_POOL];
    int unsigned set_pool [SET_POOL];
    int unsigned off_plan [PHASES];
    int unsigned off;
    int unsigned ph;
    int unsigned k;
    off_plan = '{0, 31, 16, 5, 1, 12, 16, 0};
    offset_q = sac_pkg::OFF_BITS'(4);
    for (k = 0; k < sac_pkg::NUM_SETS * sac_pkg::WAYS; k++) begin
      tag_mem[k / sac_pkg::WAYS][k % sac_pkg::WAYS] = '0;
      line_ok[k / sac_pkg::WAYS][k % sac_pkg::WAYS] = 1'b0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: address extremes, fill of one set, eviction, promotion of a hit
    // in a full set, and a hit that differs only in the block offset.
    for (k = 0; k < TAG_POOL; k++) tag_pool[k] = {$urandom, $urandom};
    addr_backlog.push_back('0);
    addr_backlog.push_back('1);
    addr_backlog.push_back('0);
    addr_backlog.push_back('1);
    for (k = 0; k < 5; k++) addr_backlog.push_back(make_addr(tag_pool[k], 5, 4, $urandom));
    addr_backlog.push_back(make_addr(tag_pool[1], 5, 4, 0));
    addr_backlog.push_back(make_addr(tag_pool[0], 5, 4, 0));
    addr_backlog.push_back(make_addr(tag_pool[2], 5, 4, 0));
    addr_backlog.push_back(make_addr(tag_pool[1], 5, 4, 0));
    addr_backlog.push_back(make_addr(tag_pool[1], 5, 4, 15));
    wait_idle();

    for (ph = 0; ph < PHASES; ph++) begin
      off = (ph == PHASES - 1) ? $urandom_range(0, 31) : off_plan[ph];
      @(posedge clk_i);
      cfg_we <= 1'b1;
      cfg_wdata <= sac_pkg::OFF_BITS'(off);
      @(posedge clk_i);
      cfg_we <= 1'b0;
      offset_q = sac_pkg::OFF_BITS'(off);
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 77;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 77;
        end
        default: begin
          send_idle_pct = 30;
          stall_pct = 30;
        end
      endcase
      for (k = 0; k < TAG_POOL; k++) tag_pool[k] = {$urandom, $urandom};
      for (k = 0; k < SET_POOL; k++) set_pool[k] = $urandom_range(0, sac_pkg::NUM_SETS - 1);
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(99) < 85) begin
          addr_backlog.push_back(make_addr(tag_pool[$urandom_range(0, TAG_POOL - 1)],
                                           set_pool[$urandom_range(0, SET_POOL - 1)],
                                           off, {$urandom, $urandom}));
        end else begin
          addr_backlog.push_back(sac_pkg::ADDR_BITS'({$urandom, $urandom}));
        end
      end
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && lookup_q.size() == 0) begin
      $display("set_assoc_cache_lru regression: pass");
    end else begin
      $display("set_assoc_cache_lru regression: fail");
    end
    $finish;
  end

endmodule

// ===== set_assoc_cache_lru.f =====
rtl/sac_pkg.sv
rtl/sac_ram.sv
rtl/sac_cell.sv
rtl/set_assoc_cache_lru.sv
tb/tb_set_assoc_cache_lru.sv
